// ----- hdl/slbc_pkg.sv -----
// shared constants, types and the stage hand-off record of the skin line breath counter
package slbc_pkg;

   localparam int MAX_COLS = 2048;
   localparam int MAX_ROWS = 1024;

   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int FILL_W   = COL_W + 1;
   localparam int ROW_W    = 10;
   localparam int RUN_W    = 11;
   localparam int THR_W    = 10;
   localparam int EDGE_W   = 16;
   localparam int BREATH_W = 15;
   localparam int CMP_W    = (COL_W > RUN_W) ? COL_W : RUN_W;

   localparam int ROW_LIMIT_I = (MAX_ROWS - 1 > 1023) ? 1023 : MAX_ROWS - 1;
   localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROW_LIMIT_I);
   localparam logic [COL_W-1:0] COL_LAST  = COL_W'(MAX_COLS - 1);

   localparam logic [RUN_W-1:0] RUN_LENGTH_RESET      = RUN_W'(120);
   localparam logic [THR_W-1:0] SWING_THRESHOLD_RESET = THR_W'(5);
   localparam logic [ROW_W-1:0] PREV_ROW_RESET        = ROW_W'(87);

   typedef enum logic [1:0] {
      MOTION_UP   = 2'd0,
      MOTION_DOWN = 2'd1,
      MOTION_HOLD = 2'd2,
      MOTION_NONE = 2'd3
   } motion_type;

   typedef enum logic {
      CSR_RUN_LENGTH      = 1'b0,
      CSR_SWING_THRESHOLD = 1'b1
   } csr_index_type;

   // one pixel after the line buffer read
   typedef struct packed {
      logic             valid;
      logic             skin;
      logic             eof;
      logic             above;
      logic [ROW_W-1:0] row;
   } scan_beat_type;

endpackage

// ----- hdl/slbc_scan.sv -----
// pixel scan stage: run, column and row counters plus the line buffer of run marks
module slbc_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               skin,
   input  logic                               eol,
   input  logic                               eof,
   input  logic [slbc_pkg::RUN_W-1:0]          run_length,
   input  logic                               hold,
   output slbc_pkg::scan_beat_type             beat
);

   logic [slbc_pkg::RUN_W-1:0]  run_ff, run_in, run_inc, need;
   logic [slbc_pkg::COL_W-1:0]  col_ff, col_in;
   logic [slbc_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [slbc_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic                        line_end, mark, written;

   logic                        valid_ff, valid_in;
   logic                        skin_ff, eof_ff, written_ff, mem_q_ff;
   logic [slbc_pkg::ROW_W-1:0]  beat_row_ff;

   logic                        mem [slbc_pkg::MAX_COLS];

   assign line_end = eol | eof;
   assign need     = (run_length == '0) ? slbc_pkg::RUN_W'(1) : run_length;
   assign run_inc  = skin ? ((run_ff != '1) ? run_ff + 1'b1 : run_ff) : '0;
   assign mark     = skin & ~line_end
                   & (slbc_pkg::CMP_W'(col_ff) > slbc_pkg::CMP_W'(need))
                   & (run_inc >= need);
   // columns below the fill count were written earlier in this frame
   assign written  = slbc_pkg::FILL_W'(col_ff) < fill_ff;

   always_comb begin
      run_in   = run_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      fill_in  = fill_ff;
      valid_in = hold ? valid_ff : 1'b0;
      if (accept) begin
         valid_in = 1'b1;
         if (slbc_pkg::FILL_W'(col_ff) >= fill_ff) begin
            fill_in = slbc_pkg::FILL_W'(col_ff) + 1'b1;
         end
         if (line_end) begin
            run_in = '0;
            col_in = '0;
            if (row_ff < slbc_pkg::ROW_LIMIT) begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            run_in = run_inc;
            if (col_ff != slbc_pkg::COL_LAST) begin
               col_in = col_ff + 1'b1;
            end
         end
         if (eof) begin
            row_in  = '0;
            fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   // read-first line buffer: old mark out, this pixel's mark in
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_q_ff    <= mem[col_ff];
         mem[col_ff] <= mark;
         skin_ff     <= skin;
         eof_ff      <= eof;
         written_ff  <= written;
         beat_row_ff <= row_ff;
      end
   end

   assign beat.valid = valid_ff;
   assign beat.skin  = skin_ff;
   assign beat.eof   = eof_ff;
   assign beat.above = mem_q_ff & written_ff;
   assign beat.row   = beat_row_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= slbc_pkg::FILL_W'(slbc_pkg::MAX_COLS))
      else $error("fill count beyond line buffer depth");

   a_hold_keeps_beat: assert property (@(posedge clock) disable iff (reset)
      hold |-> !accept)
      else $error("pixel taken while scan stage held");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && eof |=> fill_ff == '0 && row_ff == '0 && col_ff == '0)
      else $error("counters not cleared at frame end");

endmodule

// ----- hdl/slbc_track.sv -----
// frame tracking stage: lowest qualifying row, motion, breath edges and result register
module slbc_track (
   input  logic                               clock,
   input  logic                               reset,
   input  slbc_pkg::scan_beat_type             beat,
   input  logic [slbc_pkg::THR_W-1:0]          swing_threshold,
   input  logic                               rsp_ready,
   output logic                               hold,
   output logic                               rsp_valid,
   output logic                               line_found,
   output logic [slbc_pkg::ROW_W-1:0]          line_row,
   output logic [1:0]                         motion,
   output logic [slbc_pkg::BREATH_W-1:0]       breath_count
);

   logic                          hit_ff, going_up_ff, rsp_valid_ff;
   logic [slbc_pkg::ROW_W-1:0]    best_ff, prev_ff, high_ff, low_ff;
   logic [slbc_pkg::EDGE_W-1:0]   edge_ff;

   logic                          take, hit_now, hit_all, up, down, flip, swing_ok;
   logic [slbc_pkg::ROW_W-1:0]    row_sel, high_new, low_new;
   logic [slbc_pkg::EDGE_W-1:0]   edge_new;
   slbc_pkg::motion_type          motion_new;

   logic                          found_ff;
   logic [slbc_pkg::ROW_W-1:0]    row_out_ff;
   slbc_pkg::motion_type          motion_ff;
   logic [slbc_pkg::BREATH_W-1:0] breath_ff;

   // a second frame end must wait while the last result is still unread
   assign hold    = beat.valid & beat.eof & rsp_valid_ff & ~rsp_ready;
   assign take    = beat.valid & ~hold;
   assign hit_now = beat.skin & beat.above & (beat.row != '0);
   assign hit_all = hit_ff | hit_now;
   assign row_sel = hit_now ? beat.row - 1'b1 : best_ff;

   assign high_new = (row_sel > high_ff) ? row_sel : high_ff;
   assign low_new  = (row_sel < low_ff) ? row_sel : low_ff;
   assign up       = prev_ff > row_sel;
   assign down     = prev_ff < row_sel;
   assign flip     = (up & ~going_up_ff) | (down & going_up_ff);
   assign swing_ok = (high_new > low_new)
                   && ((high_new - low_new) > swing_threshold);
   assign edge_new = (flip && swing_ok && edge_ff != '1) ? edge_ff + 1'b1 : edge_ff;

   always_comb begin
      if (!hit_all) begin
         motion_new = slbc_pkg::MOTION_NONE;
      end else if (up) begin
         motion_new = slbc_pkg::MOTION_UP;
      end else if (down) begin
         motion_new = slbc_pkg::MOTION_DOWN;
      end else begin
         motion_new = slbc_pkg::MOTION_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         best_ff      <= '0;
         prev_ff      <= slbc_pkg::PREV_ROW_RESET;
         going_up_ff  <= 1'b0;
         high_ff      <= '0;
         low_ff       <= '1;
         edge_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take) begin
            if (beat.eof) begin
               hit_ff       <= 1'b0;
               best_ff      <= '0;
               rsp_valid_ff <= 1'b1;
               if (hit_all) begin
                  prev_ff <= row_sel;
                  edge_ff <= edge_new;
                  if (flip) begin
                     high_ff     <= '0;
                     low_ff      <= '1;
                     going_up_ff <= ~going_up_ff;
                  end else begin
                     high_ff <= high_new;
                     low_ff  <= low_new;
                  end
               end
            end else if (hit_now) begin
               hit_ff  <= 1'b1;
               best_ff <= row_sel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && beat.eof) begin
         found_ff   <= hit_all;
         row_out_ff <= hit_all ? row_sel : '0;
         motion_ff  <= motion_new;
         breath_ff  <= hit_all ? edge_new[slbc_pkg::EDGE_W-1:1]
                               : edge_ff[slbc_pkg::EDGE_W-1:1];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign line_found   = found_ff;
   assign line_row     = row_out_ff;
   assign motion       = motion_ff;
   assign breath_count = breath_ff;

   a_result_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(beat.valid && beat.eof))
      else $error("result raised without a frame end");

   a_no_line_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> row_out_ff == '0 && motion_ff == slbc_pkg::MOTION_NONE)
      else $error("empty frame result carries a row or motion");

   a_edge_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> edge_ff == $past(edge_ff) || edge_ff == $past(edge_ff) + 1'b1)
      else $error("edge count moved by more than one");

   a_swing_restart: assert property (@(posedge clock) disable iff (reset)
      going_up_ff != $past(going_up_ff) |-> high_ff == '0 && low_ff == '1)
      else $error("swing range not restarted on reversal");

endmodule

// ----- hdl/skin_line_breath_counter.sv -----
// top level of the skin line breath counter: register port, scan stage and tracking stage
//
//  channel  dir  handshake              payload
//  req_     in   req_tvalid/req_tready  tdata[0] pixel_skin, tlast end_of_line,
//                                       tuser end_of_frame
//  rsp_     out  rsp_tvalid/rsp_tready  tdata found, row, motion, breath_count
//  csr_     in   csr_valid/csr_ready    csr_index, csr_data
//
//  one pixel per clock while req_tready is high; a result is registered in the
//  tracking stage from the registered scan beat of the pixel that ends the frame.
//  the line buffer is a single read-first memory port: read and write of a column
//  share one edge, so neighbouring pixels never collide.
//  reset is synchronous; the line buffer needs no clearing, a fill count marks
//  which columns this frame has written.
//  req_tready drops only while one result is unread and another frame end waits.
module skin_line_breath_counter (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] pixel_skin, [7:1] zero
   input  logic        req_tlast,   // end_of_line
   input  logic        req_tuser,   // end_of_frame

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] line_found, [10:1] line_row, [12:11] motion,
                                    // [27:13] breath_count, [31:28] zero

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   logic [slbc_pkg::RUN_W-1:0]    run_length_ff;
   logic [slbc_pkg::THR_W-1:0]    swing_threshold_ff;
   logic                          accept, hold;
   slbc_pkg::scan_beat_type       beat;

   logic                          line_found;
   logic [slbc_pkg::ROW_W-1:0]    line_row;
   logic [1:0]                    motion;
   logic [slbc_pkg::BREATH_W-1:0] breath_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_length_ff      <= slbc_pkg::RUN_LENGTH_RESET;
         swing_threshold_ff <= slbc_pkg::SWING_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (slbc_pkg::csr_index_type'(csr_index))
            slbc_pkg::CSR_RUN_LENGTH: begin
               run_length_ff <= csr_data;
            end
            slbc_pkg::CSR_SWING_THRESHOLD: begin
               swing_threshold_ff <= csr_data[slbc_pkg::THR_W-1:0];
            end
            default: begin
               run_length_ff <= run_length_ff;
            end
         endcase
      end
   end

   assign req_tready = ~hold;
   assign accept     = req_tvalid & req_tready;

   slbc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .skin       (req_tdata[0]),
      .eol        (req_tlast),
      .eof        (req_tuser),
      .run_length (run_length_ff),
      .hold       (hold),
      .beat       (beat)
   );

   slbc_track u_track (
      .clock           (clock),
      .reset           (reset),
      .beat            (beat),
      .swing_threshold (swing_threshold_ff),
      .rsp_ready       (rsp_tready),
      .hold            (hold),
      .rsp_valid       (rsp_tvalid),
      .line_found      (line_found),
      .line_row        (line_row),
      .motion          (motion),
      .breath_count    (breath_count)
   );

   assign rsp_tdata = {4'b0000, breath_count, motion, line_row, line_found};

endmodule

// ----- test/tb.sv -----
// testbench for the skin line breath counter: directed pixels, random frames, scoreboard
`timescale 1ns / 100ps

module tb;
   import slbc_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 300;
   localparam int TALL_ROWS     = 1030;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic                found;
      logic [ROW_W-1:0]    row;
      motion_type          motion;
      logic [BREATH_W-1:0] breath;
   } frame_result_t;

   localparam frame_result_t NO_FRAME_RESULT = '{1'b0, 10'd0, MOTION_NONE, 15'd0};

   typedef enum bit {STEP_PIXEL, STEP_CSR} step_kind_t;

   typedef struct {
      step_kind_t       kind;
      csr_index_type    reg_index;
      logic [RUN_W-1:0] value;
      bit               skin;
      bit               eol;
      bit               eof;
      bit               typed;
      frame_result_t    want;
   } directed_step_t;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_MIXED} idle_mode_t;

   typedef struct {
      logic [RUN_W-1:0] run_length;
      logic [RUN_W-1:0] threshold;
      idle_mode_t       idling;
      bit               hold_off;
      bit               tall_frame;
      bit               wide_frame;
   } phase_plan_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [10:0] csr_data = 11'd0;

   // predictor state
   logic [RUN_W-1:0]  cfg_run_length;
   logic [THR_W-1:0]  cfg_swing_threshold;
   logic [RUN_W-1:0]  scan_run;
   logic [COL_W-1:0]  scan_col;
   logic [ROW_W-1:0]  scan_row;
   bit                above_marks [MAX_COLS];
   bit                frame_found;
   logic [ROW_W-1:0]  frame_row;
   logic [ROW_W-1:0]  last_row;
   bit                heading_up;
   logic [ROW_W-1:0]  swing_top;
   logic [ROW_W-1:0]  swing_bottom;
   logic [EDGE_W-1:0] edge_total;

   frame_result_t expected_frames [$];
   int            error_count = 0;
   int            items_sent = 0;
   int            send_gap_pct = 0;
   int            recv_stall_pct = 0;
   logic          hold_toggle = 1'b0;
   logic          hold_seen = 1'b0;
   int            hold_left = 0;

   directed_step_t directed_steps [0:28];
   phase_plan_t    phase_plan [0:5];

   skin_line_breath_counter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("skin_line_breath_counter test failed");
      $finish;
   end

   // a reversal closes the swing seen since the last one
   function automatic void close_swing();
      if (swing_top > swing_bottom && swing_top - swing_bottom > cfg_swing_threshold) begin
         if (edge_total != '1)
            edge_total++;
      end
      swing_top    = '0;
      swing_bottom = '1;
      heading_up   = !heading_up;
   endfunction

   function automatic bit predict_pixel(input bit skin, input bit eol_in, input bit eof,
                                        output frame_result_t res);
      bit               eol;
      bit               mark;
      logic [RUN_W-1:0] need;
      eol  = eol_in | eof;
      need = (cfg_run_length == '0) ? RUN_W'(1) : cfg_run_length;
      res  = NO_FRAME_RESULT;

      if (skin && above_marks[scan_col] && scan_row != '0) begin
         frame_found = 1'b1;
         frame_row   = scan_row - 1'b1;
      end
      if (skin) begin
         if (scan_run != '1)
            scan_run++;
      end else begin
         scan_run = '0;
      end
      mark = skin && !eol && scan_col > need && scan_run >= need;
      above_marks[scan_col] = mark;

      if (eol) begin
         scan_run = '0;
         scan_col = '0;
         if (scan_row < ROW_LIMIT)
            scan_row++;
      end else if (scan_col != COL_LAST) begin
         scan_col++;
      end

      if (!eof)
         return 1'b0;

      if (frame_found) begin
         res.found = 1'b1;
         res.row   = frame_row;
         if (frame_row > swing_top)
            swing_top = frame_row;
         if (frame_row < swing_bottom)
            swing_bottom = frame_row;
         if (last_row > frame_row) begin
            if (!heading_up)
               close_swing();
            res.motion = MOTION_UP;
         end else if (last_row < frame_row) begin
            if (heading_up)
               close_swing();
            res.motion = MOTION_DOWN;
         end else begin
            res.motion = MOTION_HOLD;
         end
         last_row = frame_row;
      end
      res.breath = edge_total[EDGE_W-1:1];

      foreach (above_marks[i])
         above_marks[i] = 1'b0;
      frame_found = 1'b0;
      frame_row   = '0;
      scan_row    = '0;
      scan_col    = '0;
      scan_run    = '0;
      return 1'b1;
   endfunction

   function automatic void set_idling(input idle_mode_t mode);
      send_gap_pct   = (mode == IDLE_SEND) ? 52 : (mode == IDLE_BOTH) ? 6 : 0;
      recv_stall_pct = (mode == IDLE_RECV) ? 52 : (mode == IDLE_BOTH) ? 6 : 0;
   endfunction

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [RUN_W-1:0] value);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_RUN_LENGTH)
         cfg_run_length = value;
      else
         cfg_swing_threshold = value[THR_W-1:0];
   endtask

   task automatic send_pixel(input bit skin, input bit eol, input bit eof,
                             input bit typed, input frame_result_t typed_want);
      frame_result_t predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, skin};
      req_tlast  <= eol;
      req_tuser  <= eof;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      items_sent++;
      if (predict_pixel(skin, eol, eof, predicted))
         expected_frames.push_back(typed ? typed_want : predicted);
   endtask

   // ragged rows; the frame end may or may not carry the line end as well
   task automatic send_frame(input int rows, input int min_cols, input int max_cols,
                             input int skin_pct);
      int cols;
      bit skin;
      bit eol;
      for (int r = 0; r < rows; r++) begin
         cols = $urandom_range(max_cols, min_cols);
         for (int c = 0; c < cols; c++) begin
            skin = ($urandom_range(99) < skin_pct);
            eol  = (c == cols - 1);
            if (eol && r == rows - 1)
               send_pixel(skin, $urandom_range(1), 1'b1, 1'b0, NO_FRAME_RESULT);
            else
               send_pixel(skin, eol, 1'b0, 1'b0, NO_FRAME_RESULT);
         end
      end
   endtask

   // result side: random stalls, long hold-off on request, scoreboard
   always @(posedge clock) begin : rsp_side
      frame_result_t got;
      frame_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_seen  <= hold_toggle;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found  = rsp_tdata[0];
            got.row    = rsp_tdata[10:1];
            got.motion = motion_type'(rsp_tdata[12:11]);
            got.breath = rsp_tdata[27:13];
            if (expected_frames.size() == 0) begin
               $error("unexpected result transaction: %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_frames.pop_front();
               if (got.found !== want.found) begin
                  $error("line_found: expected %0d, actual %0d", want.found, got.found);
                  error_count++;
               end
               if (got.row !== want.row) begin
                  $error("line_row: expected %0d, actual %0d", want.row, got.row);
                  error_count++;
               end
               if (got.motion !== want.motion) begin
                  $error("motion: expected %0d, actual %0d", want.motion, got.motion);
                  error_count++;
               end
               if (got.breath !== want.breath) begin
                  $error("breath_count: expected %0d, actual %0d", want.breath, got.breath);
                  error_count++;
               end
            end
         end
         if (hold_toggle != hold_seen) begin
            hold_seen  <= hold_toggle;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      int phase_end;
      int frame_no;
      int mark;
      int skin_pct;

      cfg_run_length      = RUN_LENGTH_RESET;
      cfg_swing_threshold = SWING_THRESHOLD_RESET;
      scan_run     = '0;
      scan_col     = '0;
      scan_row     = '0;
      foreach (above_marks[i])
         above_marks[i] = 1'b0;
      frame_found  = 1'b0;
      frame_row    = '0;
      last_row     = PREV_ROW_RESET;
      heading_up   = 1'b0;
      swing_top    = '0;
      swing_bottom = '1;
      edge_total   = '0;

      directed_steps = '{
         // reset settings: short rows never reach a run of 120
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 1, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 1, 1, NO_FRAME_RESULT},
         // zero run length acts as one; row 0 found, moving up from the reset row
         '{STEP_CSR,   CSR_RUN_LENGTH, 11'd0, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 1, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 1, 1, 1, '{1'b1, 10'd0, MOTION_UP, 15'd0}},
         // zero threshold, line moves down a row
         '{STEP_CSR,   CSR_SWING_THRESHOLD, 11'd0, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 1, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 1, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 1, 0, NO_FRAME_RESULT},
         // top threshold, single-pixel frame with no line
         '{STEP_CSR,   CSR_SWING_THRESHOLD, 11'd1023, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 0, 1, 1, 1, NO_FRAME_RESULT},
         // longest run length field
         '{STEP_CSR,   CSR_RUN_LENGTH, 11'd2047, 0, 0, 0, 0, NO_FRAME_RESULT},
         '{STEP_PIXEL, CSR_RUN_LENGTH, 11'd0, 1, 0, 1, 1, NO_FRAME_RESULT}
      };

      phase_plan = '{
         '{11'd1,    11'd0,    IDLE_NONE,  1'b1, 1'b1, 1'b0},
         '{11'd2,    11'd1,    IDLE_SEND,  1'b0, 1'b0, 1'b0},
         '{11'd3,    11'd1023, IDLE_RECV,  1'b0, 1'b0, 1'b0},
         '{11'd0,    11'd2,    IDLE_BOTH,  1'b0, 1'b0, 1'b0},
         '{11'd2046, 11'd5,    IDLE_SEND,  1'b0, 1'b0, 1'b1},
         '{11'd1,    11'd3,    IDLE_MIXED, 1'b1, 1'b0, 1'b0}
      };

      set_idling(IDLE_NONE);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR)
            write_register(directed_steps[i].reg_index, directed_steps[i].value);
         else
            send_pixel(directed_steps[i].skin, directed_steps[i].eol, directed_steps[i].eof,
                       directed_steps[i].typed, directed_steps[i].want);
      end

      foreach (phase_plan[p]) begin
         write_register(CSR_RUN_LENGTH, phase_plan[p].run_length);
         write_register(CSR_SWING_THRESHOLD, phase_plan[p].threshold);
         set_idling(phase_plan[p].idling);
         phase_end = items_sent + PHASE_ITEMS;
         frame_no  = 0;
         while (items_sent < phase_end) begin
            if (phase_plan[p].idling == IDLE_MIXED)
               set_idling(idle_mode_t'($urandom_range(int'(IDLE_BOTH))));
            // result side holds off while frames keep coming, so the input backs up
            if (frame_no == 1 && phase_plan[p].hold_off)
               hold_toggle <= ~hold_toggle;
            mark = items_sent;
            if (frame_no == 3 && phase_plan[p].tall_frame) begin
               send_frame(TALL_ROWS, 3, 5, 90);
               phase_end += items_sent - mark;
            end else if (frame_no == 3 && phase_plan[p].wide_frame) begin
               send_frame(3, MAX_COLS + 2, MAX_COLS + 52, 100);
               phase_end += items_sent - mark;
            end else begin
               case ($urandom_range(2))
                  0:       skin_pct = 35;
                  1:       skin_pct = 75;
                  default: skin_pct = 95;
               endcase
               send_frame($urandom_range(8, 1), 3, 12, skin_pct);
            end
            if (frame_no == 5)
               wait_results_drained();
            frame_no++;
         end
      end

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("skin_line_breath_counter test passed");
      else
         $display("skin_line_breath_counter test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/slbc_pkg.sv
hdl/slbc_scan.sv
hdl/slbc_track.sv
hdl/skin_line_breath_counter.sv
test/tb.sv
